// ===== rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: widths, opcodes, status codes and
// the request/response payload structs. No dependencies.
package cau_pkg;

   localparam int PartWidth = 16;
   localparam int FracBits  = 8;
   localparam int ProdWidth = 2 * PartWidth;          // magnitude of one product
   localparam int SumWidth  = ProdWidth + 1;          // sum of two products
   localparam int QuotWidth = PartWidth + 1;          // integer quotient kept
   localparam int DivSteps  = QuotWidth + FracBits + 1; // quotient bits incl. round bit
   localparam int DivWidth  = QuotWidth + FracBits + 1;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SAT  = 2'd1;
   localparam logic [1:0] ST_DIV0 = 2'd2;

   typedef struct packed {
      logic [1:0]                  op;
      logic signed [PartWidth-1:0] a_re;
      logic signed [PartWidth-1:0] a_im;
      logic signed [PartWidth-1:0] b_re;
      logic signed [PartWidth-1:0] b_im;
   } req_type;

   typedef struct packed {
      logic signed [PartWidth-1:0] res_re;
      logic signed [PartWidth-1:0] res_im;
      logic [1:0]                  status;
   } rsp_type;

   // One result part in sign-magnitude form: sign flag and magnitude.
   typedef struct packed {
      logic                  neg;
      logic [SumWidth-1:0]   mag;
   } smag_type;

   // Saturate a sign-magnitude value to a signed part; flag when clipped.
   function automatic logic [PartWidth:0] sat_part(input logic neg,
                                                   input logic [SumWidth-1:0] mag);
      logic [SumWidth-1:0]  lim_neg;
      logic [SumWidth-1:0]  lim_pos;
      logic [PartWidth-1:0] v;
      logic                 s;
      lim_neg = SumWidth'(1) << (PartWidth - 1);
      lim_pos = lim_neg - SumWidth'(1);
      s = 1'b0;
      if (neg) begin
         if (mag > lim_neg) begin
            v = lim_neg[PartWidth-1:0];
            s = 1'b1;
         end else begin
            v = PartWidth'(0) - mag[PartWidth-1:0];
         end
      end else begin
         if (mag > lim_pos) begin
            v = lim_pos[PartWidth-1:0];
            s = 1'b1;
         end else begin
            v = mag[PartWidth-1:0];
         end
      end
      return {s, v};
   endfunction

endpackage

// ===== rtl/cau_front.sv =====
// Front end: product stage and sign-magnitude sum stage of the unit.
// Depends on cau_pkg.
module cau_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  cau_pkg::req_type in_req,
   output logic             out_valid,
   output logic [1:0]       out_op,
   output logic             out_div0,
   output cau_pkg::smag_type out_re,
   output cau_pkg::smag_type out_im,
   output logic [cau_pkg::SumWidth-1:0] out_den
);
   import cau_pkg::*;

   // stage 1: four cross products and two squares as magnitudes
   logic                 v1_ff, v1_in;
   logic [1:0]           op1_ff;
   logic [ProdWidth-1:0] p_ff [4];
   logic [ProdWidth-1:0] p_in [4];
   logic                 n_ff [4];
   logic                 n_in [4];
   logic [ProdWidth-1:0] q_ff [2];
   logic [ProdWidth-1:0] q_in [2];
   logic [PartWidth:0]   ar_m, ai_m, br_m, bi_m;

   function automatic logic [PartWidth:0] magf(input logic signed [PartWidth-1:0] x);
      logic signed [PartWidth:0] w;
      w = {x[PartWidth-1], x};
      return w[PartWidth] ? (PartWidth+1)'(-w) : w;
   endfunction

   always_comb begin
      ar_m = magf(in_req.a_re);
      ai_m = magf(in_req.a_im);
      br_m = magf(in_req.b_re);
      bi_m = magf(in_req.b_im);
      p_in[0] = ProdWidth'(ar_m * br_m);
      p_in[1] = ProdWidth'(ai_m * bi_m);
      p_in[2] = ProdWidth'(ar_m * bi_m);
      p_in[3] = ProdWidth'(ai_m * br_m);
      n_in[0] = in_req.a_re[PartWidth-1] ^ in_req.b_re[PartWidth-1];
      n_in[1] = in_req.a_im[PartWidth-1] ^ in_req.b_im[PartWidth-1];
      n_in[2] = in_req.a_re[PartWidth-1] ^ in_req.b_im[PartWidth-1];
      n_in[3] = in_req.a_im[PartWidth-1] ^ in_req.b_re[PartWidth-1];
      q_in[0] = ProdWidth'(br_m * br_m);
      q_in[1] = ProdWidth'(bi_m * bi_m);
      // add/sub reuse the product slots with a trivial multiplier of one
      if (in_req.op == OP_ADD || in_req.op == OP_SUB) begin
         p_in[0] = ProdWidth'(ar_m);
         n_in[0] = in_req.a_re[PartWidth-1];
         p_in[1] = ProdWidth'(br_m);
         n_in[1] = in_req.b_re[PartWidth-1] ^ (in_req.op == OP_SUB);
         p_in[2] = ProdWidth'(ai_m);
         n_in[2] = in_req.a_im[PartWidth-1];
         p_in[3] = ProdWidth'(bi_m);
         n_in[3] = in_req.b_im[PartWidth-1] ^ (in_req.op == OP_SUB);
      end
      v1_in = adv ? in_valid : v1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
      end
      if (adv) begin
         op1_ff <= in_req.op;
         p_ff   <= p_in;
         n_ff   <= n_in;
         q_ff   <= q_in;
      end
   end

   // stage 2: signed sums of the products
   logic     v2_ff, v2_in;
   logic [1:0] op2_ff;
   logic     d0_ff;
   smag_type re_ff, re_in, im_ff, im_in;
   logic [SumWidth-1:0] den_ff, den_in;

   function automatic smag_type sadd(input logic n1, input logic [ProdWidth-1:0] m1,
                                     input logic n2, input logic [ProdWidth-1:0] m2);
      smag_type r;
      if (n1 == n2) begin
         r.neg = n1;
         r.mag = SumWidth'(m1) + SumWidth'(m2);
      end else if (m1 >= m2) begin
         r.neg = n1;
         r.mag = SumWidth'(m1 - m2);
      end else begin
         r.neg = n2;
         r.mag = SumWidth'(m2 - m1);
      end
      return r;
   endfunction

   always_comb begin
      unique case (op1_ff)
         OP_ADD, OP_SUB: begin
            re_in = sadd(n_ff[0], p_ff[0], n_ff[1], p_ff[1]);
            im_in = sadd(n_ff[2], p_ff[2], n_ff[3], p_ff[3]);
         end
         OP_MUL: begin
            re_in = sadd(n_ff[0], p_ff[0], ~n_ff[1], p_ff[1]);
            im_in = sadd(n_ff[2], p_ff[2], n_ff[3], p_ff[3]);
         end
         default: begin
            re_in = sadd(n_ff[0], p_ff[0], n_ff[1], p_ff[1]);
            im_in = sadd(n_ff[3], p_ff[3], ~n_ff[2], p_ff[2]);
         end
      endcase
      den_in = SumWidth'(q_ff[0]) + SumWidth'(q_ff[1]);
      v2_in  = adv ? v1_ff : v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v2_in;
      end
      if (adv) begin
         op2_ff <= op1_ff;
         re_ff  <= re_in;
         im_ff  <= im_in;
         den_ff <= den_in;
         d0_ff  <= (den_in == '0);
      end
   end

   assign out_valid = v2_ff;
   assign out_op    = op2_ff;
   assign out_div0  = d0_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_den   = den_ff;

endmodule

// ===== rtl/cau_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, for both parts.
// Gives integer+fraction quotient plus one round bit. Depends on cau_pkg.
module cau_div (
   input  logic                          clock,
   input  logic                          adv,
   input  logic [cau_pkg::SumWidth-1:0]  num_re,
   input  logic [cau_pkg::SumWidth-1:0]  num_im,
   input  logic [cau_pkg::SumWidth-1:0]  den,
   output logic [cau_pkg::DivWidth-1:0]  quo_re,
   output logic [cau_pkg::DivWidth-1:0]  quo_im
);
   import cau_pkg::*;

   // Dividend is num * 2^(FracBits+1); quotient bits above DivWidth mean
   // overflow and are caught by the sticky flag in the MSB slot.
   localparam int NumExt = SumWidth + FracBits + 1;
   localparam int RemW   = SumWidth + 1;

   logic [RemW-1:0]     rr_ff [DivSteps+1];
   logic [RemW-1:0]     ri_ff [DivSteps+1];
   logic [NumExt-1:0]   nr_ff [DivSteps+1];
   logic [NumExt-1:0]   ni_ff [DivSteps+1];
   logic [DivWidth-1:0] qr_ff [DivSteps+1];
   logic [DivWidth-1:0] qi_ff [DivSteps+1];
   logic [SumWidth-1:0] d_ff  [DivSteps+1];

   logic [RemW-1:0]     rr_in [DivSteps+1];
   logic [RemW-1:0]     ri_in [DivSteps+1];
   logic [NumExt-1:0]   nr_in [DivSteps+1];
   logic [NumExt-1:0]   ni_in [DivSteps+1];
   logic [DivWidth-1:0] qr_in [DivSteps+1];
   logic [DivWidth-1:0] qi_in [DivSteps+1];

   // The bits of the dividend above DivWidth quotient bits are first reduced
   // in stage 0 by a compare: any of them nonzero after division => overflow.
   localparam int HighBits = NumExt - DivSteps;

   always_comb begin
      logic [RemW-1:0] t;
      logic            ovr, ovi;
      ovr = (RemW'(num_re >> (SumWidth - HighBits)) >= RemW'(den)) && (den != '0);
      ovi = (RemW'(num_im >> (SumWidth - HighBits)) >= RemW'(den)) && (den != '0);
      t = '0;
      nr_in[0] = NumExt'(num_re) << (FracBits + 1);
      ni_in[0] = NumExt'(num_im) << (FracBits + 1);
      rr_in[0] = RemW'(nr_in[0] >> DivSteps);
      ri_in[0] = RemW'(ni_in[0] >> DivSteps);
      qr_in[0] = {ovr, {(DivWidth-1){1'b0}}};
      qi_in[0] = {ovi, {(DivWidth-1){1'b0}}};
      for (int s = 1; s <= DivSteps; s++) begin
         t = {rr_ff[s-1][RemW-2:0], nr_ff[s-1][DivSteps-s]};
         nr_in[s] = nr_ff[s-1];
         qr_in[s] = qr_ff[s-1];
         if (t >= RemW'(d_ff[s-1])) begin
            rr_in[s] = t - RemW'(d_ff[s-1]);
            qr_in[s][DivSteps-s] = 1'b1;
         end else begin
            rr_in[s] = t;
         end
         t = {ri_ff[s-1][RemW-2:0], ni_ff[s-1][DivSteps-s]};
         ni_in[s] = ni_ff[s-1];
         qi_in[s] = qi_ff[s-1];
         if (t >= RemW'(d_ff[s-1])) begin
            ri_in[s] = t - RemW'(d_ff[s-1]);
            qi_in[s][DivSteps-s] = 1'b1;
         end else begin
            ri_in[s] = t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s <= DivSteps; s++) begin
            rr_ff[s] <= rr_in[s];
            ri_ff[s] <= ri_in[s];
            nr_ff[s] <= nr_in[s];
            ni_ff[s] <= ni_in[s];
            qr_ff[s] <= qr_in[s];
            qi_ff[s] <= qi_in[s];
         end
         d_ff[0] <= den;
         for (int s = 1; s <= DivSteps; s++) begin
            d_ff[s] <= d_ff[s-1];
         end
      end
   end

   assign quo_re = qr_ff[DivSteps];
   assign quo_im = qi_ff[DivSteps];

endmodule

// ===== rtl/complex_arith_unit.sv =====
// Complex arithmetic unit: top level, delay line for non-divide items,
// rounding, saturation and the output register. Depends on cau_pkg,
// cau_front and cau_div.
//
// Usage
//   req_ channel carries op and the two Q8.8 complex operands; rsp_ channel
//   returns the saturated Q8.8 result and a status (ok, saturated, divide
//   by zero). One response for every request, in request order.
// Throughput
//   One transfer per cycle on both sides unless the receiver stalls. Every
//   item takes the same path: a product stage, a sum stage, a pipelined
//   divider of DivSteps + 1 stages (one quotient bit per stage, bypassed in
//   value but not in time for add/sub/mul), then a round/saturate stage into
//   the output register.
// Stall
//   The whole pipeline advances only while the output register is empty or
//   being taken, so a stalled receiver freezes every stage in place and no
//   item is lost or repeated; req_ready falls together with the stall.
// Reset
//   Synchronous, active high; clears all valid bits. No other state.
module complex_arith_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   localparam int Depth = DivSteps + 1;

   logic adv;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic                fv;
   logic [1:0]          fop;
   logic                fd0;
   smag_type            fre, fim;
   logic [SumWidth-1:0] fden;
   logic [DivWidth-1:0] qre, qim;

   // pipeline moves when the output slot is free or draining
   assign adv       = ~rsp_valid_ff | rsp_ready;
   assign req_ready = adv;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_req    (req_data),
      .out_valid (fv),
      .out_op    (fop),
      .out_div0  (fd0),
      .out_re    (fre),
      .out_im    (fim),
      .out_den   (fden)
   );

   cau_div u_div (
      .clock  (clock),
      .adv    (adv),
      .num_re (fre.mag),
      .num_im (fim.mag),
      .den    (fd0 ? SumWidth'(1) : fden),
      .quo_re (qre),
      .quo_im (qim)
   );

   // side line: valid, op and sum values travel alongside the divider
   logic       dv_ff [Depth];
   logic [1:0] dop_ff [Depth];
   logic       dd0_ff [Depth];
   smag_type   dre_ff [Depth];
   smag_type   dim_ff [Depth];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < Depth; s++) begin
            dv_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= fv;
         for (int s = 1; s < Depth; s++) begin
            dv_ff[s] <= dv_ff[s-1];
         end
      end
      if (adv) begin
         dop_ff[0] <= fop;
         dd0_ff[0] <= fd0;
         dre_ff[0] <= fre;
         dim_ff[0] <= fim;
         for (int s = 1; s < Depth; s++) begin
            dop_ff[s] <= dop_ff[s-1];
            dd0_ff[s] <= dd0_ff[s-1];
            dre_ff[s] <= dre_ff[s-1];
            dim_ff[s] <= dim_ff[s-1];
         end
      end
   end

   // rounding: ties away from zero on magnitudes
   function automatic logic [SumWidth-1:0] rnd(input logic [SumWidth-1:0] m);
      logic [SumWidth-1:0] r;
      if (FracBits == 0) begin
         r = m;
      end else begin
         r = (m >> FracBits) + SumWidth'((m >> (FracBits - 1)) & SumWidth'(1));
      end
      return r;
   endfunction

   // divider result: quotient holds one round bit below the fraction; the
   // top bit flags overflow beyond the part range
   function automatic logic [SumWidth-1:0] qrnd(input logic [DivWidth-1:0] q);
      logic [DivWidth-1:0] v;
      v = (q >> 1) + DivWidth'(q[0]);
      if (q[DivWidth-1]) begin
         v = DivWidth'({1'b1, {(PartWidth){1'b0}}});
      end
      return SumWidth'(v);
   endfunction

   logic [PartWidth:0] sr, si;
   logic [SumWidth-1:0] mr, mi;
   logic [1:0] lop;

   always_comb begin
      lop = dop_ff[Depth-1];
      unique case (lop)
         OP_ADD, OP_SUB: begin
            mr = dre_ff[Depth-1].mag;
            mi = dim_ff[Depth-1].mag;
         end
         OP_MUL: begin
            mr = rnd(dre_ff[Depth-1].mag);
            mi = rnd(dim_ff[Depth-1].mag);
         end
         default: begin
            mr = qrnd(qre);
            mi = qrnd(qim);
         end
      endcase
      sr = sat_part(dre_ff[Depth-1].neg, mr);
      si = sat_part(dim_ff[Depth-1].neg, mi);
      rsp_in.res_re = sr[PartWidth-1:0];
      rsp_in.res_im = si[PartWidth-1:0];
      rsp_in.status = (sr[PartWidth] | si[PartWidth]) ? ST_SAT : ST_OK;
      if (lop == OP_DIV && dd0_ff[Depth-1]) begin
         rsp_in.res_re = '0;
         rsp_in.res_im = '0;
         rsp_in.status = ST_DIV0;
      end
      rsp_valid_in = adv ? dv_ff[Depth-1] : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== tb/sv/cau_checker.sv =====
`timescale 1ns / 1ps
// Checker for the complex arithmetic unit: watches the req_/rsp_ transfers,
// predicts each result in fixed point and compares in order. Uses cau_pkg.
module cau_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  cau_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  cau_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending
);
   import cau_pkg::*;

   rsp_type expected_q[$];

   assign pending = expected_q.size();

   // round to nearest, ties away from zero, on a magnitude
   function automatic longint unsigned round_mag(input longint unsigned m);
      return (m >> FracBits) + ((m >> (FracBits - 1)) & 1);
   endfunction

   function automatic logic [PartWidth-1:0] clip(input bit neg, input longint unsigned m,
                                                 inout bit sat);
      longint unsigned lim_neg;
      lim_neg = 64'd1 << (PartWidth - 1);
      if (neg) begin
         if (m > lim_neg) begin
            m = lim_neg;
            sat = 1;
         end
         return PartWidth'(-m);
      end
      if (m > lim_neg - 1) begin
         m = lim_neg - 1;
         sat = 1;
      end
      return PartWidth'(m);
   endfunction

   function automatic logic [PartWidth-1:0] clip_signed(input longint v, inout bit sat);
      return clip(v < 0, v < 0 ? longint'(-v) : longint'(v), sat);
   endfunction

   function automatic logic [PartWidth-1:0] div_part(input longint num, input longint den,
                                                     inout bit sat);
      longint unsigned m, q, r;
      bit neg;
      neg = num < 0;
      m = neg ? -num : num;
      q = m / den;
      r = m % den;
      if (q > (64'd1 << (PartWidth - 1))) begin
         sat = 1;
         return clip(neg, (64'd1 << (PartWidth - 1)) + 1, sat);
      end
      for (int i = 0; i < FracBits; i++) begin
         q = q << 1;
         if (r >= den - r) begin
            r = r - (den - r);
            q = q | 1;
         end else begin
            r = r << 1;
         end
      end
      if (r >= den - r) q = q + 1;
      return clip(neg, q, sat);
   endfunction

   function automatic rsp_type complex_result(input req_type t);
      rsp_type o;
      longint ar, ai, br, bi, re, im, den;
      bit sat;
      ar = t.a_re;
      ai = t.a_im;
      br = t.b_re;
      bi = t.b_im;
      sat = 0;
      o.status = ST_OK;
      case (t.op)
         OP_ADD: begin
            o.res_re = clip_signed(ar + br, sat);
            o.res_im = clip_signed(ai + bi, sat);
         end
         OP_SUB: begin
            o.res_re = clip_signed(ar - br, sat);
            o.res_im = clip_signed(ai - bi, sat);
         end
         OP_MUL: begin
            re = ar * br - ai * bi;
            im = ar * bi + ai * br;
            o.res_re = clip(re < 0, round_mag(re < 0 ? -re : re), sat);
            o.res_im = clip(im < 0, round_mag(im < 0 ? -im : im), sat);
         end
         default: begin
            den = br * br + bi * bi;
            if (den == 0) begin
               o.res_re = '0;
               o.res_im = '0;
               o.status = ST_DIV0;
               return o;
            end
            o.res_re = div_part(ar * br + ai * bi, den, sat);
            o.res_im = div_part(ai * br - ar * bi, den, sat);
         end
      endcase
      if (sat) o.status = ST_SAT;
      return o;
   endfunction

   always_ff @(posedge clock) begin
      rsp_type want;
      int      errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready) expected_q.push_back(complex_result(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result transfer %p", rsp_data);
               errs++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data.res_re !== want.res_re) begin
                  $error("res_re: expected %0d, got %0d", want.res_re, rsp_data.res_re);
                  errs++;
               end
               if (rsp_data.res_im !== want.res_im) begin
                  $error("res_im: expected %0d, got %0d", want.res_im, rsp_data.res_im);
                  errs++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule

// ===== tb/sv/tb_complex_arith_unit.sv =====
`timescale 1ns / 1ps
// Top of the complex arithmetic unit testbench: clock, reset, request and
// response traffic, verdict. Depends on cau_pkg, cau_checker and the RTL.
module tb_complex_arith_unit;
   import cau_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;
   int      fail_count;
   int      pending;
   bit      calm;          // no idling on either side while set

   complex_arith_unit u_top (.*);

   cau_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: 1600 items with ~29% gaps and stalls plus the pipeline latency
   // finish well inside this time limit; it allows far more.
   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // Receiver: stalls at random about 29% of the time, never while calm.
   initial rsp_ready = 1'b0;
   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 29);
   end

   // Edge values for operand parts.
   function automatic logic [15:0] corner_part();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         4: return 16'h0001;
         5: return 16'h0100;
         6: return 16'hff00;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random part: full range, small magnitudes (few saturations) or edges.
   function automatic logic [15:0] rand_part();
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($signed(11'($urandom)));
         2: return 16'($signed(8'($urandom)));
         default: return corner_part();
      endcase
   endfunction

   // Holds valid until the transfer, with optional idle cycles beforehand.
   task automatic send(input req_type t);
      while (!calm && $urandom_range(99) < 29) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   initial begin
      req_type t;
      int      guard;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      calm      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: each op at the extremes, plus divide by zero and scalars.
      for (int op = 0; op < 4; op++) begin
         send('{op: 2'(op), a_re: 16'h7fff, a_im: 16'h7fff, b_re: 16'h7fff, b_im: 16'h7fff});
         send('{op: 2'(op), a_re: 16'h8000, a_im: 16'h8000, b_re: 16'h8000, b_im: 16'h8000});
         send('{op: 2'(op), a_re: 16'h8000, a_im: 16'h7fff, b_re: 16'h7fff, b_im: 16'h8000});
         send('{op: 2'(op), a_re: 16'h0180, a_im: 16'hfe80, b_re: 16'h0100, b_im: 16'h0000});
         send('{op: 2'(op), a_re: 16'h0001, a_im: 16'hffff, b_re: 16'h0000, b_im: 16'h0000});
      end
      send('{op: OP_DIV, a_re: 16'h0000, a_im: 16'h0000, b_re: 16'h0000, b_im: 16'h0000});
      send('{op: OP_DIV, a_re: 16'h7fff, a_im: 16'h8000, b_re: 16'h0001, b_im: 16'h0000});
      send('{op: OP_DIV, a_re: 16'h0100, a_im: 16'h0000, b_re: 16'h0000, b_im: 16'h0300});
      send('{op: OP_MUL, a_re: 16'h0080, a_im: 16'h0000, b_re: 16'h0001, b_im: 16'h0000});

      // Random part, with a calm stretch in the middle.
      for (int n = 0; n < 1600; n++) begin
         calm = (n >= 700 && n < 900);
         t.op   = 2'($urandom);
         t.a_re = rand_part();
         t.a_im = rand_part();
         t.b_re = rand_part();
         t.b_im = rand_part();
         if (t.op == OP_DIV && $urandom_range(19) == 0) begin
            t.b_re = '0;
            t.b_im = '0;
         end
         send(t);
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      guard = 0;
      while (pending != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
